/* design/gbce_pkg.sv */
// ----------------------------------------------------------------------------
// gbce_pkg
// Shared constants, register indexes and types of the clamped-edge blur.
// ----------------------------------------------------------------------------
package gbce_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OCOL_W     = 10;
  localparam int WGT_W      = 17;
  localparam int FW_W       = 11;
  localparam int RAD_W      = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE  = 3'd6;

  // reset values
  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 16'd768;
  localparam logic [RAD_W-1:0] RST_BLUR_RADIUS  = 2'd2;
  localparam logic [WGT_W-1:0] RST_WEIGHT_CTR   = 17'd65536;

  typedef logic [3:0][WGT_W-1:0] weights_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TAPS,
    B_DRAIN,
    B_EMIT
  } back_state_e;

  // 1D weight by distance from the center; zero beyond three
  function automatic logic [WGT_W-1:0] tap_weight(weights_t w, logic [2:0] d);
    logic [WGT_W-1:0] r;
    case (d)
      3'd0:    r = w[0];
      3'd1:    r = w[1];
      3'd2:    r = w[2];
      3'd3:    r = w[3];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/gaussian_blur_clamped_edges.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_clamped_edges
// Streaming RGB Gaussian blur over a square window with clamp-to-edge sampling.
// ----------------------------------------------------------------------------
// Pixels enter in raster order through push/full; each word is taken by the
// front and parked in a two-word queue. The back stores the pixel into a
// (2*MAX_RADIUS+1)-row line store, then for every window that pixel
// completes it walks all (2R+1)^2 taps through the single line-store read
// port, one tap per cycle, followed by a pipe drain and a load of the result
// register, which waits while the previous result word is untaken. The back
// takes the next pixel from the queue only once its windows are done. Edge
// pixels on the last row or last column emit a run of outputs ordered by row
// then column; run_end marks the last word of a run. Weights are Q1.16
// one-sided 1D taps; the 2D weight is their product, accumulation is exact
// and the sum is taken >>32 and saturated at 255. The line store is not
// cleared at reset; a window never reads an entry that its frame has not
// written. Change configuration only while the block is idle.
// ----------------------------------------------------------------------------
module gaussian_blur_clamped_edges #(
  parameter int MAX_RADIUS = gbce_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gbce_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [gbce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbce_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel words in
  input  logic                           push,
  output logic                           full,
  input  logic [gbce_pkg::PIX_W-1:0]     pixel_red_i,
  input  logic [gbce_pkg::PIX_W-1:0]     pixel_green_i,
  input  logic [gbce_pkg::PIX_W-1:0]     pixel_blue_i,
  // result words out
  output logic                           empty,
  input  logic                           pop,
  output logic [gbce_pkg::PIX_W-1:0]     blur_red_o,
  output logic [gbce_pkg::PIX_W-1:0]     blur_green_o,
  output logic [gbce_pkg::PIX_W-1:0]     blur_blue_o,
  output logic [gbce_pkg::OCOL_W-1:0]    out_col_o,
  output logic [gbce_pkg::ROW_W-1:0]     out_row_o,
  output logic                           run_end_o
);
  import gbce_pkg::*;

  localparam int RING = 2 * MAX_RADIUS + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = $clog2(RING);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  // pix + col + row + slot + ylo + yhi + xlo + xhi + emit
  localparam int QW   = 24 + CW + ROW_W + SW + 2 * ROW_W + 2 * CW + 1;

  // configuration registers
  logic [FW_W-1:0]  frame_width_q;
  logic [ROW_W-1:0] frame_height_q;
  logic [RAD_W-1:0] blur_radius_q;
  weights_t         weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      blur_radius_q  <= RST_BLUR_RADIUS;
      weights_q      <= {{(3*WGT_W){1'b0}}, RST_WEIGHT_CTR};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:   frame_width_q  <= cfg_wdata_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height_q <= cfg_wdata_i[ROW_W-1:0];
        CFG_BLUR_RADIUS:   blur_radius_q  <= cfg_wdata_i[RAD_W-1:0];
        CFG_WEIGHT_CENTER: weights_q[0]   <= cfg_wdata_i;
        CFG_WEIGHT_ONE:    weights_q[1]   <= cfg_wdata_i;
        CFG_WEIGHT_TWO:    weights_q[2]   <= cfg_wdata_i;
        CFG_WEIGHT_THREE:  weights_q[3]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective geometry: width 1..MAX_WIDTH, height >= 1, radius 1..MAX_RADIUS
  logic [CW:0]      w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [RW-1:0]    r_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width_q);
    end
    h_eff = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;
    if (blur_radius_q == '0) begin
      r_eff = RW'(1);
    end else if (32'(blur_radius_q) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(blur_radius_q);
    end
  end

  logic          accept;
  logic [QW-1:0] f_item, q_item;
  logic          q_valid, q_pop;

  assign accept = push && !full;

  gbce_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .QW         (QW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .w_eff_i       (w_eff),
    .h_eff_i       (h_eff),
    .r_eff_i       (r_eff),
    .item_o        (f_item)
  );

  gbce_queue #(
    .DW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (f_item),
    .full_o  (full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  gbce_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .QW         (QW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .w_eff_i      (w_eff),
    .h_eff_i      (h_eff),
    .r_eff_i      (r_eff),
    .weights_i    (weights_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .blur_red_o   (blur_red_o),
    .blur_green_o (blur_green_o),
    .blur_blue_o  (blur_blue_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .run_end_o    (run_end_o)
  );

endmodule

/* design/gbce_front.sv */
// ----------------------------------------------------------------------------
// gbce_front
// Tracks raster position and works out which windows each pixel completes.
// ----------------------------------------------------------------------------
module gbce_front #(
  parameter int MAX_RADIUS = gbce_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gbce_pkg::DEF_MAX_WIDTH,
  parameter int QW         = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [gbce_pkg::PIX_W-1:0]  pixel_red_i,
  input  logic [gbce_pkg::PIX_W-1:0]  pixel_green_i,
  input  logic [gbce_pkg::PIX_W-1:0]  pixel_blue_i,
  input  logic [$clog2(MAX_WIDTH):0]  w_eff_i,
  input  logic [gbce_pkg::ROW_W-1:0]  h_eff_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] r_eff_i,
  output logic [QW-1:0]               item_o
);
  import gbce_pkg::*;

  localparam int RING = 2 * MAX_RADIUS + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = $clog2(RING);

  typedef struct packed {
    logic [23:0]      pix;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [SW-1:0]    slot;
    logic [ROW_W-1:0] ylo;
    logic [ROW_W-1:0] yhi;
    logic [CW-1:0]    xlo;
    logic [CW-1:0]    xhi;
    logic             emit;
  } cmd_t;

  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SW-1:0]    slot_q, slot_d;

  logic [CW-1:0]    c0;
  logic [ROW_W-1:0] r0;
  logic [SW-1:0]    s0;
  logic [CW:0]      c1;
  logic             last_row, last_col, yok, xok;
  cmd_t             cmd;

  function automatic logic [SW-1:0] slot_inc(logic [SW-1:0] s);
    return (s == SW'(RING - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    c0 = col_q;
    r0 = row_q;
    s0 = slot_q;
    // geometry shrank under us: wrap first
    if ({1'b0, col_q} >= w_eff_i) begin
      c0 = '0;
      r0 = row_q + 1'b1;
      s0 = slot_inc(slot_q);
    end
    if (r0 >= h_eff_i) begin
      r0 = '0;
    end

    last_row = (r0 == h_eff_i - 1'b1);
    last_col = ({1'b0, c0} == w_eff_i - 1'b1);
    yok      = last_row || (r0 >= ROW_W'(r_eff_i));
    xok      = last_col || (c0 >= CW'(r_eff_i));

    cmd.pix  = {pixel_red_i, pixel_green_i, pixel_blue_i};
    cmd.col  = c0;
    cmd.row  = r0;
    cmd.slot = s0;
    cmd.ylo  = (r0 >= ROW_W'(r_eff_i)) ? r0 - ROW_W'(r_eff_i) : '0;
    cmd.yhi  = last_row ? r0 : cmd.ylo;
    cmd.xlo  = (c0 >= CW'(r_eff_i)) ? c0 - CW'(r_eff_i) : '0;
    cmd.xhi  = last_col ? c0 : cmd.xlo;
    cmd.emit = yok && xok;
    item_o   = QW'(cmd);

    // advance position
    c1     = {1'b0, c0} + 1'b1;
    col_d  = CW'(c1);
    row_d  = r0;
    slot_d = s0;
    if (c1 >= w_eff_i) begin
      col_d  = '0;
      slot_d = slot_inc(s0);
      row_d  = r0 + 1'b1;
      if (row_d >= h_eff_i) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

endmodule

/* design/gbce_queue.sv */
// ----------------------------------------------------------------------------
// gbce_queue
// Two-entry FIFO between the front and the back.
// ----------------------------------------------------------------------------
module gbce_queue #(
  parameter int DW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output logic [DW-1:0] rdata_o
);
  logic [1:0][DW-1:0] ent_q;
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = ent_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wp_q] <= wdata_i;
    end
  end

endmodule

/* design/gbce_back.sv */
// ----------------------------------------------------------------------------
// gbce_back
// Line store, tap sequencer, multiply-accumulate pipe and result register.
// ----------------------------------------------------------------------------
module gbce_back #(
  parameter int MAX_RADIUS = gbce_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gbce_pkg::DEF_MAX_WIDTH,
  parameter int QW         = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  logic [QW-1:0]               q_item_i,
  output logic                        q_pop_o,
  input  logic [$clog2(MAX_WIDTH):0]  w_eff_i,
  input  logic [gbce_pkg::ROW_W-1:0]  h_eff_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] r_eff_i,
  input  gbce_pkg::weights_t          weights_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [gbce_pkg::PIX_W-1:0]  blur_red_o,
  output logic [gbce_pkg::PIX_W-1:0]  blur_green_o,
  output logic [gbce_pkg::PIX_W-1:0]  blur_blue_o,
  output logic [gbce_pkg::OCOL_W-1:0] out_col_o,
  output logic [gbce_pkg::ROW_W-1:0]  out_row_o,
  output logic                        run_end_o
);
  import gbce_pkg::*;

  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(RING);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int TW    = $clog2(RING);
  localparam int MA    = $clog2(RING * MAX_WIDTH);
  localparam int NTAPS = RING * RING;
  localparam int WTW   = 2 * WGT_W;
  localparam int PW    = WTW + PIX_W;
  localparam int AW    = PW + $clog2(NTAPS);

  typedef struct packed {
    logic [23:0]      pix;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [SW-1:0]    slot;
    logic [ROW_W-1:0] ylo;
    logic [ROW_W-1:0] yhi;
    logic [CW-1:0]    xlo;
    logic [CW-1:0]    xhi;
    logic             emit;
  } cmd_t;

  back_state_e state_q, state_d;
  cmd_t        head, cur_q;

  logic [TW-1:0]    ty_q, tx_q, two_r, dya, dxa;
  logic [ROW_W-1:0] y_q, sy;
  logic [CW-1:0]    x_q, sx;
  logic signed [ROW_W+1:0] ys;
  logic signed [CW+1:0]    xs;
  logic [SW-1:0]    back_rows, rslot;
  logic [SW:0]      slot_sum;
  logic [MA-1:0]    raddr, waddr;
  logic [WGT_W-1:0] wy, wx;

  logic [23:0]      mem [RING*MAX_WIDTH];
  logic [23:0]      rd_q;
  logic [WTW-1:0]   wt_q;
  logic             v1_q, v2_q;
  logic [PW-1:0]    pr_q, pg_q, pb_q;
  logic [AW-1:0]    acc_r_q, acc_g_q, acc_b_q;

  logic             ov_q;
  logic [PIX_W-1:0] o_r_q, o_g_q, o_b_q;
  logic [OCOL_W-1:0] o_col_q;
  logic [ROW_W-1:0] o_row_q;
  logic             o_end_q;

  logic mem_we, issue, out_load, last_tap, last_out;

  assign head = cmd_t'(q_item_i);

  function automatic logic [PIX_W-1:0] sat8(logic [AW-1:0] a);
    return (|a[AW-1:40]) ? 8'hFF : a[39:32];
  endfunction

  // ---- tap address and weights ----
  always_comb begin
    two_r = TW'({r_eff_i, 1'b0});

    ys = signed'((ROW_W+2)'(y_q)) + signed'((ROW_W+2)'(ty_q))
       - signed'((ROW_W+2)'(r_eff_i));
    if (ys < 0) begin
      sy = '0;
    end else if (ys >= signed'((ROW_W+2)'(h_eff_i))) begin
      sy = h_eff_i - 1'b1;
    end else begin
      sy = ys[ROW_W-1:0];
    end
    back_rows = SW'(cur_q.row - sy);
    slot_sum  = (SW+1)'(cur_q.slot) + (SW+1)'(RING) - (SW+1)'(back_rows);
    if (slot_sum >= (SW+1)'(RING)) begin
      slot_sum = slot_sum - (SW+1)'(RING);
    end
    rslot = SW'(slot_sum);

    xs = signed'((CW+2)'(x_q)) + signed'((CW+2)'(tx_q)) - signed'((CW+2)'(r_eff_i));
    if (xs < 0) begin
      sx = '0;
    end else if (xs >= signed'((CW+2)'(w_eff_i))) begin
      sx = CW'(w_eff_i - 1'b1);
    end else begin
      sx = CW'(xs);
    end

    raddr = MA'(rslot) * MA'(MAX_WIDTH) + MA'(sx);
    waddr = MA'(head.slot) * MA'(MAX_WIDTH) + MA'(head.col);

    dya = (ty_q >= TW'(r_eff_i)) ? ty_q - TW'(r_eff_i) : TW'(r_eff_i) - ty_q;
    dxa = (tx_q >= TW'(r_eff_i)) ? tx_q - TW'(r_eff_i) : TW'(r_eff_i) - tx_q;
    wy  = tap_weight(weights_i, 3'(dya));
    wx  = tap_weight(weights_i, 3'(dxa));

    last_tap = (tx_q == two_r) && (ty_q == two_r);
    last_out = (y_q == cur_q.yhi) && (x_q == cur_q.xhi);
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (q_valid_i && head.emit) state_d = B_TAPS;
      B_TAPS:  if (last_tap) state_d = B_DRAIN;
      B_DRAIN: if (!v1_q && !v2_q) state_d = B_EMIT;
      B_EMIT:  if (out_load) state_d = last_out ? B_IDLE : B_TAPS;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        q_pop_o = q_valid_i;
        mem_we  = q_valid_i;
      end
      B_TAPS:  issue = 1'b1;
      B_DRAIN: ;
      B_EMIT:  out_load = !ov_q || pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // ---- line store ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= head.pix;
    end
    if (issue) begin
      rd_q <= mem[raddr];
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    if (issue) begin
      wt_q <= wy * wx;
      if (tx_q == two_r) begin
        tx_q <= '0;
        ty_q <= (ty_q == two_r) ? '0 : ty_q + 1'b1;
      end else begin
        tx_q <= tx_q + 1'b1;
      end
    end
    if (v1_q) begin
      pr_q <= PW'(rd_q[23:16]) * PW'(wt_q);
      pg_q <= PW'(rd_q[15:8])  * PW'(wt_q);
      pb_q <= PW'(rd_q[7:0])   * PW'(wt_q);
    end
    if (v2_q) begin
      acc_r_q <= acc_r_q + AW'(pr_q);
      acc_g_q <= acc_g_q + AW'(pg_q);
      acc_b_q <= acc_b_q + AW'(pb_q);
    end
    if (q_pop_o) begin
      cur_q   <= head;
      y_q     <= head.ylo;
      x_q     <= head.xlo;
      ty_q    <= '0;
      tx_q    <= '0;
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end
    if (out_load) begin
      o_r_q   <= sat8(acc_r_q);
      o_g_q   <= sat8(acc_g_q);
      o_b_q   <= sat8(acc_b_q);
      o_col_q <= OCOL_W'(x_q);
      o_row_q <= y_q;
      o_end_q <= last_out;
      if (!last_out) begin
        if (x_q == cur_q.xhi) begin
          x_q <= cur_q.xlo;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
        acc_r_q <= '0;
        acc_g_q <= '0;
        acc_b_q <= '0;
      end
    end
  end

  assign empty_o      = !ov_q;
  assign blur_red_o   = o_r_q;
  assign blur_green_o = o_g_q;
  assign blur_blue_o  = o_b_q;
  assign out_col_o    = o_col_q;
  assign out_row_o    = o_row_q;
  assign run_end_o    = o_end_q;

endmodule

/* design/gbce_checker.sv */
// ----------------------------------------------------------------------------
// gbce_checker
// Port-level checks for the clamped-edge blur, bound to the top level.
// ----------------------------------------------------------------------------
module gbce_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [gbce_pkg::PIX_W-1:0]     blur_red_o,
  input logic [gbce_pkg::PIX_W-1:0]     blur_green_o,
  input logic [gbce_pkg::PIX_W-1:0]     blur_blue_o,
  input logic [gbce_pkg::OCOL_W-1:0]    out_col_o,
  input logic [gbce_pkg::ROW_W-1:0]     out_row_o,
  input logic                           run_end_o
);

  // a waiting result word holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(blur_red_o) && $stable(blur_green_o)
      && $stable(blur_blue_o) && $stable(out_col_o) && $stable(out_row_o)
      && $stable(run_end_o))
    else $error("result word changed while stalled");

  // handshake lines are always driven to known levels
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({push, pop, full, empty}))
    else $error("unknown level on a handshake line");

  // a presented result word carries known fields
  a_fields_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({blur_red_o, blur_green_o, blur_blue_o, out_col_o,
                            out_row_o, run_end_o}))
    else $error("unknown field in a presented result word");

endmodule

bind gaussian_blur_clamped_edges gbce_checker u_gbce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .blur_red_o   (blur_red_o),
  .blur_green_o (blur_green_o),
  .blur_blue_o  (blur_blue_o),
  .out_col_o    (out_col_o),
  .out_row_o    (out_row_o),
  .run_end_o    (run_end_o)
);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clamped-edge RGB Gaussian blur.
// ----------------------------------------------------------------------------
// Pixel words go in through push/full. Each accepted word updates a local
// line-store predictor, which queues the blurred words that the pixel should
// release. A monitor pops result words, with random stalls until the calm
// closing part, and compares every field against the oldest queued word.
// Geometry is only changed between frames, or where the counters wrap
// cleanly, so no window reads a line-store entry that was never written.
// ----------------------------------------------------------------------------
module tb_top;
  import gbce_pkg::*;

  localparam int RING     = 2 * DEF_MAX_RADIUS + 1;
  localparam int DRAIN_CY = 80;   // outlasts one radius-3 window walk of 49 taps

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [OCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } blur_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic full;
  logic [PIX_W-1:0] pixel_red_i = '0, pixel_green_i = '0, pixel_blue_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [PIX_W-1:0] blur_red_o, blur_green_o, blur_blue_o;
  logic [OCOL_W-1:0] out_col_o;
  logic [ROW_W-1:0] out_row_o;
  logic run_end_o;

  gaussian_blur_clamped_edges u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .pixel_red_i, .pixel_green_i, .pixel_blue_i,
    .empty, .pop, .blur_red_o, .blur_green_o, .blur_blue_o,
    .out_col_o, .out_row_o, .run_end_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---- predictor state: line store, raster counters, register copies ----
  logic [23:0]      line_mem [RING][DEF_MAX_WIDTH];
  int               pix_col, pix_row, ring_row;
  logic [FW_W-1:0]  reg_width;
  logic [ROW_W-1:0] reg_height;
  logic [RAD_W-1:0] reg_radius;
  logic [WGT_W-1:0] reg_wgt [4];

  blur_word_t blur_q [$];   // words the block still owes us
  int  n_fail    = 0;
  int  n_pixels  = 0;
  int  n_results = 0;
  bit  calm      = 1'b0;    // no idling on either side in the closing part

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    n_fail++;
  endtask

  function automatic longint unsigned tap(int d);
    return (d <= 3) ? longint'(reg_wgt[d]) : 64'd0;
  endfunction

  function automatic int clampi(int v, int n);
    return (v < 0) ? 0 : (v >= n) ? n - 1 : v;
  endfunction

  // weighted window sum at (x,y); taps live in the ring relative to pix_row
  function automatic blur_word_t window_blur(int x, int y, int w, int h, int rad);
    longint unsigned acc [3];
    longint unsigned wy, wt, v;
    int sy, sx, back, slot;
    logic [23:0] px;
    blur_word_t o;
    acc = '{0, 0, 0};
    for (int dy = -rad; dy <= rad; dy++) begin
      sy   = clampi(y + dy, h);
      back = pix_row - sy;
      slot = (ring_row + RING - (back % RING)) % RING;
      wy   = tap(dy < 0 ? -dy : dy);
      for (int dx = -rad; dx <= rad; dx++) begin
        sx = clampi(x + dx, w);
        wt = wy * tap(dx < 0 ? -dx : dx);
        px = line_mem[slot][sx];
        acc[0] += px[23:16] * wt;
        acc[1] += px[15:8] * wt;
        acc[2] += px[7:0] * wt;
      end
    end
    for (int i = 0; i < 3; i++) begin
      v = acc[i] >> 32;
      acc[i] = (v > 255) ? 255 : v;
    end
    o.red   = acc[0][7:0];
    o.green = acc[1][7:0];
    o.blue  = acc[2][7:0];
    o.col   = x[OCOL_W-1:0];
    o.row   = y[ROW_W-1:0];
    o.last  = 1'b0;
    return o;
  endfunction

  // one accepted pixel: store it, queue every window it completes
  task automatic predict_pixel(input logic [23:0] rgb);
    int w, h, rad, ylo, yhi, xlo, xhi;
    bit yok, xok;
    blur_word_t o;
    w   = (reg_width < 1) ? 1 : (reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_width;
    h   = (reg_height < 1) ? 1 : reg_height;
    rad = (reg_radius < 1) ? 1 : reg_radius;
    // frame shrunk under the counters: wrap first
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
      ring_row = (ring_row + 1) % RING;
    end
    if (pix_row >= h) pix_row = 0;
    line_mem[ring_row][pix_col] = rgb;
    // bottom row / right column flush everything still pending
    yok = (pix_row == h - 1) || (pix_row >= rad);
    ylo = (pix_row >= rad) ? pix_row - rad : 0;
    xok = (pix_col == w - 1) || (pix_col >= rad);
    xlo = (pix_col >= rad) ? pix_col - rad : 0;
    if (yok && xok) begin
      yhi = (pix_row == h - 1) ? pix_row : ylo;
      xhi = (pix_col == w - 1) ? pix_col : xlo;
      for (int y = ylo; y <= yhi; y++)
        for (int x = xlo; x <= xhi; x++) begin
          o = window_blur(x, y, w, h, rad);
          o.last = (y == yhi) && (x == xhi);
          blur_q.push_back(o);
        end
    end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      ring_row = (ring_row + 1) % RING;
      pix_row++;
      if (pix_row >= h) pix_row = 0;
    end
  endtask

  // ---- pixel sender ----
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    pixel_red_i   <= r;
    pixel_green_i <= g;
    pixel_blue_i  <= b;
    do @(posedge clk_i); while (full);
    predict_pixel({r, g, b});
    n_pixels++;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  // keep sending until the raster counters are back at the frame origin
  task automatic send_frame();
    do send_random(1); while (pix_col != 0 || pix_row != 0);
  endtask

  // all owed words popped, then let a silent pixel finish its store cycle
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:   reg_width  = val[FW_W-1:0];
      CFG_FRAME_HEIGHT:  reg_height = val[ROW_W-1:0];
      CFG_BLUR_RADIUS:   reg_radius = val[RAD_W-1:0];
      CFG_WEIGHT_CENTER: reg_wgt[0] = val[WGT_W-1:0];
      CFG_WEIGHT_ONE:    reg_wgt[1] = val[WGT_W-1:0];
      CFG_WEIGHT_TWO:    reg_wgt[2] = val[WGT_W-1:0];
      default:           reg_wgt[3] = val[WGT_W-1:0];
    endcase
  endtask

  // full register set, written back to back while the block is quiet
  task automatic configure(input int w, input int h, input int rad,
                           input int c, input int o1, input int o2, input int o3);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BLUR_RADIUS, rad);
    write_reg(CFG_WEIGHT_CENTER, c);
    write_reg(CFG_WEIGHT_ONE, o1);
    write_reg(CFG_WEIGHT_TWO, o2);
    write_reg(CFG_WEIGHT_THREE, o3);
    cfg_we_i <= 1'b0;
  endtask

  // ---- result side: random pop stalls, field-by-field compare ----
  int pop_hold = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      pop <= rst_ni;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 4);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    blur_word_t want;
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (blur_q.size() == 0) begin
        report($sformatf("unexpected word col %0d row %0d", out_col_o, out_row_o));
      end else begin
        want = blur_q.pop_front();
        if (blur_red_o !== want.red)
          report($sformatf("red %0d, want %0d", blur_red_o, want.red));
        if (blur_green_o !== want.green)
          report($sformatf("green %0d, want %0d", blur_green_o, want.green));
        if (blur_blue_o !== want.blue)
          report($sformatf("blue %0d, want %0d", blur_blue_o, want.blue));
        if (out_col_o !== want.col)
          report($sformatf("col %0d, want %0d", out_col_o, want.col));
        if (out_row_o !== want.row)
          report($sformatf("row %0d, want %0d", out_row_o, want.row));
        if (run_end_o !== want.last)
          report($sformatf("run_end %0b, want %0b", run_end_o, want.last));
      end
    end
  end

  // ---- tests ----

  // tiny frame, normalized kernel, pixel extremes
  task automatic test_small_frame();
    configure(4, 3, 1, 32768, 16384, 0, 0);
    for (int i = 0; i < 12; i++)
      send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, i[2] ? 8'h00 : 8'hFF);
  endtask

  // zero width, height and radius clamp to 1; single-pixel frames
  task automatic test_register_clamp();
    configure(0, 0, 0, 65536, 0, 0, 65536);
    send_random(3);
  endtask

  // largest radius with every weight at 1.0: sums pin at 255
  task automatic test_saturation();
    configure(3, 2, 3, 65536, 65536, 65536, 65536);
    send_frame();
  endtask

  // single-column, very tall frame; the next frame wraps the rows back
  task automatic test_tall_column();
    configure(1, 65535, 1, 65536, 32768, 0, 0);
    send_random(6);
  endtask

  // width above the limit clamps to the full line; next frame wraps columns
  task automatic test_wide_line();
    configure(2047, 1, 2, $urandom_range(0, 65536), $urandom_range(0, 32768),
              $urandom_range(0, 16384), 0);
    send_random(24);
  endtask

  // random small frames with random kernels
  task automatic test_random_frames(input int n_items);
    int start, w, h;
    start = n_pixels;
    while (n_pixels - start < n_items) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 1))
        configure(w, h, $urandom_range(0, 3), $urandom_range(16384, 40000),
                  $urandom_range(0, 16384), $urandom_range(0, 8192),
                  $urandom_range(0, 4096));
      else
        configure(w, h, $urandom_range(0, 3), $urandom_range(0, 65536),
                  $urandom_range(0, 65536), $urandom_range(0, 65536),
                  $urandom_range(0, 65536));
      if (n_pixels - start > (n_items * 3) / 4) calm = 1'b1;
      send_frame();
    end
  endtask

  initial begin
    pix_col  = 0;
    pix_row  = 0;
    ring_row = 0;
    reg_width  = RST_FRAME_WIDTH;
    reg_height = RST_FRAME_HEIGHT;
    reg_radius = RST_BLUR_RADIUS;
    reg_wgt    = '{RST_WEIGHT_CTR, '0, '0, '0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_frame();
    test_register_clamp();
    test_saturation();
    test_tall_column();
    test_wide_line();
    test_random_frames(80);

    settle();
    $display("covered %0d pixels and %0d blurred words over small, clamped,", n_pixels,
             n_results);
    $display("saturating, tall, wide and random frames at radius 1 to 3");
    if (n_fail == 0 && blur_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words never seen", n_fail, blur_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("timeout with %0d words outstanding", blur_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
